FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Both expect a clock named clk in scope; GBN_ASSERT also expects an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define GBN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define GBN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gbn_pkg.sv
package gbn_pkg;

  // Field and register widths
  localparam int SEQ_W        = 16;
  localparam int WIN_W        = 7;
  localparam int OUT_DATA_W   = 24;

  // Most results one item may release
  localparam int MAX_RESULTS  = 64;
  localparam int MAX_WINDOW_DEF = 64;

  // Jobs buffered between front and back
  localparam int QUEUE_DEPTH  = 2;

  // Request kinds carried in in_tuser
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_ACK    = 1'b1;

  // Register indexes
  localparam logic CFG_TOTAL  = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  // One planned burst of sequence numbers
  typedef struct packed {
    logic [SEQ_W-1:0] first;   // first sequence number to send
    logic [SEQ_W-1:0] lim_m1;  // last sequence number to send
    logic             empty;   // nothing to send, emit a status result
    logic             retx;    // burst is a retransmission
    logic             done;    // base has reached the packet total
  } job_t;

endpackage

FILE: hw/rtl/go_back_n_sender_window_unit.sv
// Go-Back-N sender window. Write total_packets (index 0) and window_size
// (index 1) while idle, then send a start transaction (in_tuser = 0) followed
// by acknowledgements (in_tuser = 1, ack number in in_tdata). Each input
// transaction yields the run of sequence numbers that may now go out, one per
// output transaction with tuser = 1, or a single status transaction with
// tuser = 0; tlast marks the end of each run. The front end takes an input
// transaction through four steps (capture, window update, limit, hand-off to
// the job queue); the back end loads a job and then emits its results, up
// to the window size (at most 64) per job. A two-entry job queue lets the
// front end take the next item while the back end is still emitting. Window
// sizes of 0 act as 1 and sizes above MAX_WINDOW or 64 are saturated.
module go_back_n_sender_window_unit #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: ack_num[15:0]; in_tuser: req_type[0]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gbn_pkg::SEQ_W-1:0]      in_tdata,
  input  logic                           in_tuser,
  // out_tdata: seq_num[15:0], is_retransmit[16], all_done[17], zero[23:18]
  // out_tuser: has_packet[0]; out_tlast: last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gbn_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast,
  // Register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0]      cfg_data
);

  gbn_pkg::job_t front_job, back_job;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  // Window bookkeeping and burst planning
  gbn_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // Job queue
  gbn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Result emission
  gbn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (back_job),
    .job_valid  (back_valid),
    .job_ready  (back_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/gbn_front.sv
module gbn_front #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [gbn_pkg::SEQ_W-1:0]  in_tdata,
  input  logic                       in_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0]  cfg_data,
  output gbn_pkg::job_t              job,
  output logic                       job_valid,
  input  logic                       job_ready
);

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int WW = gbn_pkg::WIN_W;
  localparam int WIN_CAP = (MAX_WINDOW < gbn_pkg::MAX_RESULTS) ? MAX_WINDOW
                                                               : gbn_pkg::MAX_RESULTS;
  localparam logic [WW-1:0] CAP_V = WW'(WIN_CAP);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_PLAN, ST_PUSH} state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] total_r, total_nxt;
  logic [WW-1:0] window_r, window_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic          req_r, req_nxt;
  logic [SW-1:0] ack_r, ack_nxt;
  logic          retx_r, retx_nxt;
  logic [SW-1:0] limit_r, limit_nxt;
  logic          done_r, done_nxt;

  logic [SW:0]   ack_inc;
  logic [SW-1:0] new_base;
  logic [WW-1:0] eff_win;
  logic [SW:0]   win_end;
  logic          burst_empty;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Base after an ack, clamped to the total
  assign ack_inc  = {1'b0, ack_r} + (SW+1)'(1);
  assign new_base = (ack_inc > {1'b0, total_r}) ? total_r : ack_inc[SW-1:0];

  // Window size saturated to 1..cap
  always_comb begin
    if (window_r == '0) begin
      eff_win = WW'(1);
    end else if (window_r > CAP_V) begin
      eff_win = CAP_V;
    end else begin
      eff_win = window_r;
    end
  end
  assign win_end = {1'b0, base_r} + {{(SW+1-WW){1'b0}}, eff_win};

  // Job handed to the back end
  assign burst_empty = (next_r >= limit_r);
  assign job.first   = next_r;
  assign job.lim_m1  = limit_r - SW'(1);
  assign job.empty   = burst_empty;
  assign job.retx    = retx_r;
  assign job.done    = done_r;
  assign job_valid   = (state_r == ST_PUSH);

  // Next-state logic
  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    window_nxt = window_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    req_nxt    = req_r;
    ack_nxt    = ack_r;
    retx_nxt   = retx_r;
    limit_nxt  = limit_r;
    done_nxt   = done_r;

    if (cfg_valid) begin
      if (cfg_index == gbn_pkg::CFG_TOTAL) begin
        total_nxt = cfg_data;
      end else if (cfg_index == gbn_pkg::CFG_WINDOW) begin
        window_nxt = cfg_data[WW-1:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = in_tuser;
          ack_nxt   = in_tdata;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (req_r == gbn_pkg::REQ_START) begin
          base_nxt = '0;
          next_nxt = '0;
          retx_nxt = 1'b0;
        end else if (ack_r >= base_r) begin
          base_nxt = new_base;
          next_nxt = (next_r < new_base) ? new_base : next_r;
          retx_nxt = 1'b0;
        end else begin
          // Ack below the base: go back and resend the window
          next_nxt = base_r;
          retx_nxt = 1'b1;
        end
        state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        limit_nxt = (win_end > {1'b0, total_r}) ? total_r : win_end[SW-1:0];
        done_nxt  = (base_r >= total_r);
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (job_ready) begin
          next_nxt  = burst_empty ? next_r : limit_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      total_r  <= '0;
      window_r <= WW'(1);
      base_r   <= '0;
      next_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      window_r <= window_nxt;
      base_r   <= base_nxt;
      next_r   <= next_nxt;
    end
    req_r   <= req_nxt;
    ack_r   <= ack_nxt;
    retx_r  <= retx_nxt;
    limit_r <= limit_nxt;
    done_r  <= done_nxt;
  end

endmodule

FILE: hw/rtl/gbn_queue.sv
module gbn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  gbn_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output gbn_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int DEPTH = gbn_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  gbn_pkg::job_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/gbn_back.sv
module gbn_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gbn_pkg::job_t                     job,
  input  logic                              job_valid,
  output logic                              job_ready,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gbn_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int PAD = gbn_pkg::OUT_DATA_W - SW - 2;

  logic          active_r, active_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] lim_r, lim_nxt;
  logic          empty_r, empty_nxt;
  logic          retx_r, retx_nxt;
  logic          done_r, done_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic [SW-1:0] oseq_r, oseq_nxt;
  logic          ohas_r, ohas_nxt;
  logic          oretx_r, oretx_nxt;
  logic          odone_r, odone_nxt;
  logic          olast_r, olast_nxt;

  logic          slot_free;
  logic          final_one;

  assign slot_free  = !ovalid_r || out_tready;
  assign final_one  = empty_r || (cur_r == lim_r);
  assign job_ready  = !active_r;

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ohas_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {{PAD{1'b0}}, odone_r, oretx_r, oseq_r};

  // Burst sequencer and output register
  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    lim_nxt    = lim_r;
    empty_nxt  = empty_r;
    retx_nxt   = retx_r;
    done_nxt   = done_r;
    ovalid_nxt = ovalid_r && !out_tready;
    oseq_nxt   = oseq_r;
    ohas_nxt   = ohas_r;
    oretx_nxt  = oretx_r;
    odone_nxt  = odone_r;
    olast_nxt  = olast_r;

    if (!active_r) begin
      if (job_valid) begin
        active_nxt = 1'b1;
        cur_nxt    = job.first;
        lim_nxt    = job.lim_m1;
        empty_nxt  = job.empty;
        retx_nxt   = job.retx;
        done_nxt   = job.done;
      end
    end else if (slot_free) begin
      ovalid_nxt = 1'b1;
      ohas_nxt   = !empty_r;
      oseq_nxt   = empty_r ? '0 : cur_r;
      oretx_nxt  = !empty_r && retx_r;
      odone_nxt  = done_r;
      olast_nxt  = final_one;
      cur_nxt    = cur_r + SW'(1);
      if (final_one) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cur_r   <= cur_nxt;
    lim_r   <= lim_nxt;
    empty_r <= empty_nxt;
    retx_r  <= retx_nxt;
    done_r  <= done_nxt;
    oseq_r  <= oseq_nxt;
    ohas_r  <= ohas_nxt;
    oretx_r <= oretx_nxt;
    odone_r <= odone_nxt;
    olast_r <= olast_nxt;
  end

endmodule

FILE: hw/rtl/gbn_checker.sv
`include "assert_macros.svh"

module gbn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gbn_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tlast
);

  localparam int SW = gbn_pkg::SEQ_W;

  logic                           out_stall;
  logic                           out_status;
  logic                           run_more;
  logic                           pkt_valid;
  logic [SW-1:0]                  out_seq;
  logic [gbn_pkg::OUT_DATA_W+1:0] out_word;

  assign out_stall  = out_tvalid && !out_tready;
  assign out_status = out_tvalid && !out_tuser;
  assign run_more   = out_tvalid && out_tready && out_tuser && !out_tlast;
  assign pkt_valid  = out_tvalid && out_tuser;
  assign out_seq    = out_tdata[SW-1:0];
  assign out_word   = {out_tdata, out_tuser, out_tlast};

  // A stalled result transaction holds
  `GBN_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "result changed while stalled")

  // Status results end their run and carry no sequence number
  `GBN_ASSERT(a_status_form, out_status |-> out_tlast && out_tdata[16:0] == 17'd0, "bad status result")

  // Within a run, the next packet follows at once with the next number
  `GBN_ASSERT(a_run_step, run_more |=> pkt_valid && out_seq == $past(out_seq) + SW'(1), "gap in run")

  // Reset empties the output register
  `GBN_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (.*);

FILE: bench/go_back_n_sender_window_unit_test.sv
`timescale 1ns / 100ps

module go_back_n_sender_window_unit_test;

  localparam int SW = gbn_pkg::SEQ_W;

  // Request kinds and register indexes
  localparam logic REQ_START  = gbn_pkg::REQ_START;
  localparam logic REQ_ACK    = gbn_pkg::REQ_ACK;
  localparam logic REG_TOTAL  = gbn_pkg::CFG_TOTAL;
  localparam logic REG_WINDOW = gbn_pkg::CFG_WINDOW;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 80;   // full window of 64 plus front-end cycles
  localparam int LONG_HOLD     = 400;

  typedef struct packed {
    logic          has;
    logic [SW-1:0] seq;
    logic          retx;
    logic          done;
    logic          last;
  } send_result_t;

  typedef enum {ROW_START, ROW_ACK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [SW-1:0] val;
    logic          reg_idx;
    bit            pinned;     // status result with all_done typed in
    logic          pin_done;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [SW-1:0]                  in_tdata;    // ack_num[15:0]
  logic                           in_tuser;    // req_type[0]
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [gbn_pkg::OUT_DATA_W-1:0] out_tdata;   // seq_num[15:0], is_retransmit[16], all_done[17]
  logic                           out_tuser;   // has_packet[0]
  logic                           out_tlast;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_index;
  logic [SW-1:0]                  cfg_data;

  // Window state mirrored by the predictor
  int pred_total;
  int pred_win;
  int pred_base;
  int pred_next;

  send_result_t expected_sends[$];
  dir_row_t     dir_rows[$];

  int err_count = 0;
  int cycle_count = 0;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;

  go_back_n_sender_window_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s at cycle %0d, got %0h, want %0h", what, cycle_count, got, want);
    err_count++;
  endtask

  // Apply one transaction to the window and queue the sequence numbers it releases
  task automatic advance_window(input logic req, input logic [SW-1:0] ack);
    int   nb;
    int   lim;
    int   w;
    int   n;
    logic retx;
    logic done;
    retx = 1'b0;
    if (req == REQ_START) begin
      pred_base = 0;
      pred_next = 0;
    end else if (int'(ack) >= pred_base) begin
      nb = int'(ack) + 1;
      if (nb > pred_total) nb = pred_total;
      pred_base = nb;
      if (pred_next < pred_base) pred_next = pred_base;
    end else begin
      // stale ack: go back to the base and resend the window
      pred_next = pred_base;
      retx = 1'b1;
    end
    done = (pred_base >= pred_total);
    w = (pred_win == 0) ? 1 : pred_win;
    if (w > gbn_pkg::MAX_WINDOW_DEF) w = gbn_pkg::MAX_WINDOW_DEF;
    if (w > gbn_pkg::MAX_RESULTS) w = gbn_pkg::MAX_RESULTS;
    lim = pred_base + w;
    if (lim > pred_total) lim = pred_total;
    n = 0;
    while (pred_next < lim && n < gbn_pkg::MAX_RESULTS) begin
      expected_sends.push_back(send_result_t'{1'b1, pred_next[SW-1:0], retx, done, 1'b0});
      n++;
      pred_next = (pred_next + 1) & 32'hFFFF;
    end
    if (n == 0)
      expected_sends.push_back(send_result_t'{1'b0, {SW{1'b0}}, 1'b0, done, 1'b1});
    else
      expected_sends[$].last = 1'b1;
  endtask

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic req, input logic [SW-1:0] ack,
                           input bit pinned, input logic pin_done);
    int prior;
    @(negedge clk);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= ack;
    do @(posedge clk); while (!in_tready);
    prior = expected_sends.size();
    advance_window(req, ack);
    if (pinned) begin
      while (expected_sends.size() > prior) void'(expected_sends.pop_back());
      expected_sends.push_back(send_result_t'{1'b0, {SW{1'b0}}, 1'b0, pin_done, 1'b1});
    end
  endtask

  // Wait until every queued result has come out, then let the block go quiet
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_sends.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TOTAL) pred_total = int'(data);
    else pred_win = int'(data & 16'h007F);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [SW-1:0] val,
                         input logic reg_idx, input bit pinned, input logic pin_done);
    dir_row_t r;
    r.kind     = kind;
    r.val      = val;
    r.reg_idx  = reg_idx;
    r.pinned   = pinned;
    r.pin_done = pin_done;
    dir_rows.push_back(r);
  endtask

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin : check_results
    send_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sends.size() == 0) begin
        report_mismatch("result with none expected", out_tdata, 0);
      end else begin
        want = expected_sends.pop_front();
        if (out_tuser !== want.has) report_mismatch("has_packet", out_tuser, want.has);
        if (out_tdata[15:0] !== want.seq) report_mismatch("seq_num", out_tdata[15:0], want.seq);
        if (out_tdata[16] !== want.retx)
          report_mismatch("is_retransmit", out_tdata[16], want.retx);
        if (out_tdata[17] !== want.done) report_mismatch("all_done", out_tdata[17], want.done);
        if (out_tdata[23:18] !== 6'd0) report_mismatch("tdata padding", out_tdata[23:18], 0);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  initial begin
    logic [SW-1:0] r_ack;
    logic [SW-1:0] r_val;
    int            pick;

    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    pred_total    = 0;
    pred_win      = 1;
    pred_base     = 0;
    pred_next     = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows; pinned rows are status results read straight off the spec
    // empty transfer after reset: ack ignored on start, ack beyond the total
    add_row(ROW_START, 16'hFFFF, REG_TOTAL, 1, 1'b1);
    add_row(ROW_ACK,   16'hFFFF, REG_TOTAL, 1, 1'b1);
    add_row(ROW_ACK,   16'h0000, REG_TOTAL, 1, 1'b1);
    // small transfer: slide, go back, finish, stale ack after done
    add_row(ROW_CFG,   16'd10,   REG_TOTAL, 0, 1'b0);
    add_row(ROW_CFG,   16'd4,    REG_WINDOW, 0, 1'b0);
    add_row(ROW_START, 16'h1234, REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'd1,    REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'd0,    REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'hFFFF, REG_TOTAL, 1, 1'b1);
    add_row(ROW_ACK,   16'h0000, REG_TOTAL, 1, 1'b1);
    // zero window acts as one
    add_row(ROW_CFG,   16'hFFFF, REG_TOTAL, 0, 1'b0);
    add_row(ROW_CFG,   16'h0000, REG_WINDOW, 0, 1'b0);
    add_row(ROW_START, 16'h0000, REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'd0,    REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'd0,    REG_TOTAL, 0, 1'b0);
    // oversized window saturates; acks at the top of the sequence space
    add_row(ROW_CFG,   16'hFFFF, REG_WINDOW, 0, 1'b0);
    add_row(ROW_START, 16'h5A5A, REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'hFFFE, REG_TOTAL, 1, 1'b1);
    add_row(ROW_ACK,   16'hFFFF, REG_TOTAL, 1, 1'b1);
    // total lowered mid-transfer
    add_row(ROW_CFG,   16'd100,  REG_TOTAL, 0, 1'b0);
    add_row(ROW_CFG,   16'd64,   REG_WINDOW, 0, 1'b0);
    add_row(ROW_START, 16'h0000, REG_TOTAL, 0, 1'b0);
    add_row(ROW_CFG,   16'd20,   REG_TOTAL, 0, 1'b0);
    add_row(ROW_ACK,   16'd5,    REG_TOTAL, 1, 1'b0);
    add_row(ROW_ACK,   16'd40,   REG_TOTAL, 1, 1'b1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].val);
      end else begin
        send_item((dir_rows[i].kind == ROW_START) ? REQ_START : REQ_ACK, dir_rows[i].val,
                  dir_rows[i].pinned, dir_rows[i].pin_done);
      end
    end

    // Random transfers across idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 83; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 83; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      for (int run = 0; run < 2; run++) begin
        settle_block();
        // packet total: mostly short transfers, some at the extremes
        pick = $urandom_range(99);
        if (pick < 70) r_val = SW'($urandom_range(150, 1));
        else if (pick < 78) r_val = '0;
        else if (pick < 88) r_val = 16'hFFFF - SW'($urandom_range(100));
        else r_val = SW'($urandom_range(65535));
        write_reg(REG_TOTAL, r_val);
        // window: mostly small, upper data bits sometimes set
        pick = $urandom_range(99);
        if (pick < 70) r_val = SW'($urandom_range(8, 0));
        else if (pick < 85) r_val = SW'($urandom_range(64, 9));
        else r_val = SW'($urandom_range(127));
        if ($urandom_range(3) == 0) r_val[15:7] = 9'($urandom_range(511));
        write_reg(REG_WINDOW, r_val);

        send_item(REQ_START, SW'($urandom_range(65535)), 0, 1'b0);
        if (ph == 0 && run == 1) hold_req = 1'b1;

        for (int k = 0; k < 49; k++) begin
          if (k == 24) settle_block();
          pick = $urandom_range(99);
          if (pick < 8) begin
            send_item(REQ_START, SW'($urandom_range(65535)), 0, 1'b0);
          end else begin
            if (pick < 70 && pred_next > pred_base)
              r_ack = SW'(pred_base + $urandom_range(pred_next - pred_base - 1));
            else if (pick < 82 && pred_base > 0)
              r_ack = SW'($urandom_range(pred_base - 1));
            else if (pick < 90 && pred_base > 0)
              r_ack = SW'(pred_base - 1);
            else
              r_ack = SW'($urandom_range(65535));
            send_item(REQ_ACK, r_ack, 0, 1'b0);
          end
        end
      end
    end

    settle_block();
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
